// ===== src/bsst_pkg.sv =====
// Shared types and constants for the binary search sorted table unit.
// No dependencies; imported by the controller, the top level and the checker.
`timescale 1ns / 1ps

package bsst_pkg;

  // Fixed widths of the request and result fields
  localparam int ENTRY_IDX_W = 8;
  localparam int ENTRY_VAL_W = 16;
  localparam int LEFT_W      = 8;
  localparam int RIGHT_W     = 9;
  localparam int POS_W       = 8;

  // Request commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } bsst_state_t;

endpackage

// ===== src/bsst_table.sv =====
// Code table storage: one write port, one read port, registered read data.
// No package dependencies; used by bsst_ctrl through the top level.
`timescale 1ns / 1ps

module bsst_table #(
  parameter int DEPTH = 256,
  parameter int CW    = 16,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [CW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [CW-1:0] rdata
);

  logic [CW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bsst_ctrl.sv =====
// Search sequencer: request decode, bound registers, one probe per cycle,
// and the result register. Depends on bsst_pkg; drives bsst_table.
`timescale 1ns / 1ps

module bsst_ctrl
  import bsst_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int CODE_WIDTH  = 16,
  parameter int IDX_W       = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [ENTRY_IDX_W-1:0]    entry_index,
  input  logic [ENTRY_VAL_W-1:0]    entry_value,
  input  logic [LEFT_W-1:0]         search_left,
  input  logic signed [RIGHT_W-1:0] search_right,
  input  logic [ENTRY_VAL_W-1:0]    search_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      found,
  output logic [POS_W-1:0]          position,
  output logic                      mem_we,
  output logic [IDX_W-1:0]          mem_waddr,
  output logic [CODE_WIDTH-1:0]     mem_wdata,
  output logic                      mem_re,
  output logic [IDX_W-1:0]          mem_raddr,
  input  logic [CODE_WIDTH-1:0]     mem_rdata
);

  // bounds carry one spare bit above the index range plus a sign bit
  localparam int BW = ((IDX_W > LEFT_W) ? IDX_W : LEFT_W) + 2;
  localparam logic signed [BW-1:0] MAX_IDX = BW'(TABLE_DEPTH - 1);

  function automatic logic signed [BW-1:0] mid_of(input logic signed [BW-1:0] l,
                                                  input logic signed [BW-1:0] h);
    return l + ((h - l) >>> 1);
  endfunction

  bsst_state_t state, state_next;

  logic signed [BW-1:0] lo, lo_next;
  logic signed [BW-1:0] hi, hi_next;
  logic signed [BW-1:0] mid, mid_next;
  logic [CODE_WIDTH-1:0] key, key_next;
  logic                  res_found, res_found_next;
  logic [POS_W-1:0]      res_pos, res_pos_next;
  logic                  out_load;
  logic                  out_found_next;
  logic [POS_W-1:0]      out_pos_next;

  logic signed [BW-1:0] init_lo, init_hi, right_ext, init_mid;
  logic                 init_empty;
  logic                 hit;
  logic signed [BW-1:0] st_lo, st_hi, st_mid;
  logic                 st_cross;
  logic                 out_free;
  logic                 write_ok;

  assign write_ok  = 32'(entry_index) < TABLE_DEPTH;
  assign mem_waddr = IDX_W'(entry_index);
  assign mem_wdata = CODE_WIDTH'(entry_value);

  // initial bounds, right side saturated to the last entry
  assign right_ext  = BW'(search_right);
  assign init_lo    = signed'(BW'(search_left));
  assign init_hi    = (right_ext > MAX_IDX) ? MAX_IDX : right_ext;
  assign init_empty = init_hi < init_lo;
  assign init_mid   = mid_of(init_lo, init_hi);

  // probe result for the entry at mid, read last cycle
  assign hit      = mem_rdata == key;
  assign st_lo    = (mem_rdata > key) ? lo : mid + BW'(1);
  assign st_hi    = (mem_rdata > key) ? mid - BW'(1) : hi;
  assign st_cross = st_hi < st_lo;
  assign st_mid   = mid_of(st_lo, st_hi);

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    key_next       = key;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = mid[IDX_W-1:0];
    out_load       = 1'b0;
    out_found_next = res_found;
    out_pos_next   = res_pos;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_LOAD) begin
            mem_we = write_ok;
          end else begin
            key_next = CODE_WIDTH'(search_value);
            if (init_empty) begin
              res_found_next = 1'b0;
              res_pos_next   = '0;
              out_found_next = 1'b0;
              out_pos_next   = '0;
              if (out_free) begin
                out_load = 1'b1;
              end else begin
                state_next = ST_FINISH;
              end
            end else begin
              lo_next    = init_lo;
              hi_next    = init_hi;
              mid_next   = init_mid;
              mem_re     = 1'b1;
              mem_raddr  = init_mid[IDX_W-1:0];
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (hit || st_cross) begin
          res_found_next = hit;
          res_pos_next   = hit ? POS_W'(unsigned'(mid)) : '0;
          out_found_next = res_found_next;
          out_pos_next   = res_pos_next;
          if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          lo_next   = st_lo;
          hi_next   = st_hi;
          mid_next  = st_mid;
          mem_re    = 1'b1;
          mem_raddr = st_mid[IDX_W-1:0];
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    mid       <= mid_next;
    key       <= key_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    if (out_load) begin
      found    <= out_found_next;
      position <= out_pos_next;
    end
  end

endmodule

// ===== src/binary_search_sorted_table_unit.sv =====
// Binary search over a software-loaded table of character codes. A load request
// (cmd 0) writes one entry and gives no result; an index beyond the table is
// dropped. A search request (cmd 1) issues its first probe when it is taken;
// each probe is one read of the table's single read port followed by one
// compare, and the search ends on a hit or when the bounds cross. An empty
// range answers without a probe. Requests are taken one at a time; a waiting
// result sits in the output register and does not block the next request.
// Table contents are undefined until written, and there is no clearing pass
// after reset.
// Depends on bsst_pkg, bsst_table and bsst_ctrl.
`timescale 1ns / 1ps

module binary_search_sorted_table_unit
  import bsst_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int CODE_WIDTH  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [ENTRY_IDX_W-1:0]    entry_index,
  input  logic [ENTRY_VAL_W-1:0]    entry_value,
  input  logic [LEFT_W-1:0]         search_left,
  input  logic signed [RIGHT_W-1:0] search_right,
  input  logic [ENTRY_VAL_W-1:0]    search_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      found,
  output logic [POS_W-1:0]          position
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [CODE_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [CODE_WIDTH-1:0] mem_rdata;

  bsst_table #(
    .DEPTH(TABLE_DEPTH),
    .CW   (CODE_WIDTH),
    .AW   (IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bsst_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CODE_WIDTH (CODE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_left (search_left),
    .search_right(search_right),
    .search_value(search_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .position    (position),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule

// ===== src/bsst_checker.sv =====
// Port-level checks for the binary search sorted table unit, bound to the top.
// Depends on bsst_pkg and binary_search_sorted_table_unit.
`timescale 1ns / 1ps

module bsst_checker
  import bsst_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      cmd,
  input logic [LEFT_W-1:0]         search_left,
  input logic signed [RIGHT_W-1:0] search_right,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      found,
  input logic [POS_W-1:0]          position
);

  logic search_nonempty;
  assign search_nonempty = (32'(search_left) < TABLE_DEPTH) &&
                           ($signed(search_right) >= $signed({1'b0, search_left}));

  // loads never produce a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_LOAD |=> !$rose(out_valid))
    else $error("result appeared after a load request");

  // a miss always reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("miss reported with nonzero position");

  // a search over a nonempty range keeps the block busy for at least one probe
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_SEARCH && search_nonempty |=> !in_ready)
    else $error("request taken during a search");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
    else $error("stalled result changed");

endmodule

bind binary_search_sorted_table_unit bsst_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_bsst_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .cmd         (cmd),
  .search_left (search_left),
  .search_right(search_right),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .position    (position)
);
